FILE: src/sfe_pkg.sv
// shared types, constants and helpers for the scaler frame energy decoder
package sfe_pkg;

  localparam int unsigned MaxWords   = 10000;
  localparam int unsigned WordCntW   = 14;
  localparam int unsigned FrameSlots = 10;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned NumHold    = 7;
  localparam int unsigned NumChan    = 8;
  localparam int unsigned ScaleW     = 63;
  localparam int unsigned EnergyW    = 48;
  localparam int unsigned DivSteps   = ScaleW;
  localparam int unsigned DivCntW    = 6;
  localparam int unsigned JobDepth   = 2;

  localparam logic [SlotW-1:0] SlotChanD = 4'd3;
  localparam logic [SlotW-1:0] SlotSub   = 4'd4;
  localparam logic [SlotW-1:0] SlotAdd   = 4'd5;
  localparam logic [SlotW-1:0] SlotChanE = 4'd6;
  localparam logic [SlotW-1:0] SlotLast  = 4'd9;

  localparam logic [ScaleW-1:0]  EnergyPosMaxQ = 63'h7FFF_FFFF_FFFF;
  localparam logic [ScaleW-1:0]  EnergyNegMaxQ = 63'h8000_0000_0000;
  localparam logic [EnergyW-1:0] EnergyPosMax  = 48'h7FFF_FFFF_FFFF;
  localparam logic [EnergyW-1:0] EnergyNegMax  = 48'h8000_0000_0000;

  typedef struct packed {
    logic [NumChan-1:0][31:0] chans;
    logic [31:0]              pos;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jobq_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

  function automatic logic [31:0] nz_count(input logic [31:0] v);
    nz_count = (v == 32'd0) ? 32'd1 : v;
  endfunction

endpackage

FILE: src/scaler_frame_energy_decoder.sv
// top level of the scaler frame energy decoder
//
//   channel | ports                          | accepted when
//   --------+--------------------------------+---------------------
//   input   | in_push, in_full, in_*         | in_push && !in_full
//   result  | out_empty, out_pop, out_*      | out_pop && !out_empty
//   config  | cfg_we, cfg_wdata              | cfg_we
//
// words are taken one per cycle while in_full is low; one result leaves per ten-word frame
// the shift-subtract divider works on one frame at a time and takes
// the next frame from the queue only once it is back in idle
// a two-entry frame queue sits between the front end and the divider
// in_full is high while that queue holds two frames; a synchronous reset clears it
module scaler_frame_energy_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [31:0]                in_count_word,
  input  logic                       in_frame_start,
  input  logic signed [31:0]         in_encoder_start,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [31:0]                out_chan_a,
  output logic [31:0]                out_chan_b,
  output logic [31:0]                out_chan_c,
  output logic [31:0]                out_chan_d,
  output logic [31:0]                out_chan_e,
  output logic [31:0]                out_chan_f,
  output logic [31:0]                out_chan_g,
  output logic [31:0]                out_chan_h,
  output logic signed [47:0]         out_energy,
  output logic                       out_energy_invalid,
  input  logic                       cfg_we,
  input  logic [sfe_pkg::ScaleW-1:0] cfg_wdata
);
  import sfe_pkg::*;

  logic [ScaleW-1:0]        scale_r;
  logic                     acc;
  logic                     job_push, job_pop;
  job_t                     wr_job, rd_job;
  jobq_stat_t               jstat;
  logic                     res_valid;
  logic [NumChan-1:0][31:0] res_chans;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  assign in_full = jstat.full;
  assign acc     = in_push && !jstat.full;

  sfe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .count_word    (in_count_word),
    .frame_start   (in_frame_start),
    .encoder_start (in_encoder_start),
    .job_push      (job_push),
    .job           (wr_job)
  );

  sfe_jobq u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_job (wr_job),
    .pop    (job_pop),
    .rd_job (rd_job),
    .stat   (jstat)
  );

  sfe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .scale       (scale_r),
    .jstat       (jstat),
    .job         (rd_job),
    .job_pop     (job_pop),
    .pop         (out_pop && !out_empty),
    .res_valid   (res_valid),
    .res_chans   (res_chans),
    .res_energy  (out_energy),
    .res_invalid (out_energy_invalid)
  );

  assign out_empty  = !res_valid;
  assign out_chan_a = res_chans[0];
  assign out_chan_b = res_chans[1];
  assign out_chan_c = res_chans[2];
  assign out_chan_d = res_chans[3];
  assign out_chan_e = res_chans[4];
  assign out_chan_f = res_chans[5];
  assign out_chan_g = res_chans[6];
  assign out_chan_h = res_chans[7];

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !jstat.full)
    else $error("frame pushed into a full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !jstat.empty)
    else $error("divider took a frame from an empty queue");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_energy_invalid) |-> (out_energy == 48'sd0))
    else $error("invalid energy is not zero");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (jstat.full && !job_pop) |=> jstat.full)
    else $error("queue drained without a pop");
`endif

endmodule

FILE: src/sfe_front.sv
// front end: slot tracking, count capture and encoder position per frame
module sfe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [31:0]         count_word,
  input  logic                frame_start,
  input  logic signed [31:0]  encoder_start,
  output logic                job_push,
  output sfe_pkg::job_t       job
);
  import sfe_pkg::*;

  logic [SlotW-1:0]    slot_r, slot_nxt, slot_eff;
  logic [WordCntW-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic [31:0]         pos_r, pos_nxt, pos_eff;
  logic [31:0]         hold_r [NumHold];
  logic                take;

  always_comb begin
    slot_eff = frame_start ? '0 : slot_r;
    cnt_eff  = frame_start ? '0 : cnt_r;
    pos_eff  = frame_start ? encoder_start : pos_r;
    take     = acc && (cnt_eff < WordCntW'(MaxWords));
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    if (acc) begin
      slot_nxt = slot_eff;
      cnt_nxt  = cnt_eff;
      pos_nxt  = pos_eff;
    end
    if (take) begin
      case (slot_eff)
        SlotSub: pos_nxt = pos_eff - count_word;
        SlotAdd: pos_nxt = pos_eff + count_word;
        default: pos_nxt = pos_eff;
      endcase
      slot_nxt = (slot_eff == SlotLast) ? '0 : slot_eff + 1'b1;
      cnt_nxt  = cnt_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      cnt_r  <= '0;
      pos_r  <= '0;
    end else begin
      slot_r <= slot_nxt;
      cnt_r  <= cnt_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NumHold; k++) begin
      if (take && (slot_eff == ((k <= int'(SlotChanD)) ? SlotW'(k) : SlotW'(k + 2)))) begin
        hold_r[k] <= nz_count(count_word);
      end
    end
  end

  always_comb begin
    job_push = take && (slot_eff == SlotLast);
    for (int k = 0; k < NumHold; k++) begin
      job.chans[k] = hold_r[k];
    end
    job.chans[NumChan-1] = nz_count(count_word);
    job.pos = pos_eff;
  end

endmodule

FILE: src/sfe_jobq.sv
// two-entry queue of finished frames between front end and divider
module sfe_jobq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sfe_pkg::job_t       wr_job,
  input  logic                pop,
  output sfe_pkg::job_t       rd_job,
  output sfe_pkg::jobq_stat_t stat
);
  import sfe_pkg::*;

  job_t       mem_r [JobDepth];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_job;
  end

  assign rd_job     = mem_r[rd_ptr_r];
  assign stat.full  = (fill_r == 2'(JobDepth));
  assign stat.empty = (fill_r == 2'd0);

endmodule

FILE: src/sfe_back.sv
// back end: bit-serial energy division, saturation and result register
module sfe_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [sfe_pkg::ScaleW-1:0] scale,
  input  sfe_pkg::jobq_stat_t        jstat,
  input  sfe_pkg::job_t              job,
  output logic                       job_pop,
  input  logic                       pop,
  output logic                       res_valid,
  output logic [sfe_pkg::NumChan-1:0][31:0] res_chans,
  output logic signed [sfe_pkg::EnergyW-1:0] res_energy,
  output logic                       res_invalid
);
  import sfe_pkg::*;

  back_state_t              state_r, state_nxt;
  logic [DivCntW-1:0]       step_r;
  logic [ScaleW-1:0]        quo_r;
  logic [31:0]              rem_r, div_r;
  logic                     neg_r, zero_r;
  logic [NumChan-1:0][31:0] chans_r;
  logic                     out_valid_r;
  logic [NumChan-1:0][31:0] out_chans_r;
  logic [EnergyW-1:0]       out_energy_r;
  logic                     out_inv_r;
  logic [32:0]              trial;
  logic                     fits;
  logic                     out_free, load_out;
  logic [EnergyW-1:0]       energy_val;

  assign out_free = !out_valid_r || pop;
  assign trial    = {rem_r, quo_r[ScaleW-1]};
  assign fits     = (trial >= {1'b0, div_r});

  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!jstat.empty) begin
          job_pop   = 1'b1;
          state_nxt = (job.pos == 32'd0) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == '0) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (zero_r) begin
      energy_val = '0;
    end else if (!neg_r) begin
      energy_val = (quo_r > EnergyPosMaxQ) ? EnergyPosMax : quo_r[EnergyW-1:0];
    end else if (quo_r > EnergyNegMaxQ) begin
      energy_val = EnergyNegMax;
    end else begin
      energy_val = '0 - quo_r[EnergyW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (out_valid_r && !pop) || load_out;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      chans_r <= job.chans;
      neg_r   <= job.pos[31];
      zero_r  <= (job.pos == 32'd0);
      div_r   <= job.pos[31] ? (32'd0 - job.pos) : job.pos;
      quo_r   <= scale;
      rem_r   <= '0;
      step_r  <= DivCntW'(DivSteps - 1);
    end else if (state_r == ST_DIV) begin
      rem_r  <= fits ? 32'(trial - {1'b0, div_r}) : trial[31:0];
      quo_r  <= {quo_r[ScaleW-2:0], fits};
      step_r <= step_r - 1'b1;
    end
    if (load_out) begin
      out_chans_r  <= chans_r;
      out_energy_r <= energy_val;
      out_inv_r    <= zero_r;
    end
  end

  assign res_valid   = out_valid_r;
  assign res_chans   = out_chans_r;
  assign res_energy  = out_energy_r;
  assign res_invalid = out_inv_r;

endmodule

FILE: tb/sv/scaler_frame_energy_decoder_test.sv
// self-checking testbench for the scaler frame energy decoder
module scaler_frame_energy_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sfe_pkg::*;

  localparam int SettleCycles = 250;
  localparam int QuietLimit   = 5000;
  localparam int PhaseWords   = 380;

  typedef struct packed {
    logic [31:0] data;
    logic        start;
    logic [31:0] enc;
  } scaler_word_t;

  typedef struct packed {
    logic [NumChan-1:0][31:0] chan;
    logic signed [EnergyW-1:0] energy;
    logic                      invalid;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [31:0] in_count_word = '0;
  logic in_frame_start = 1'b0;
  logic signed [31:0] in_encoder_start = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [31:0] out_chan_a, out_chan_b, out_chan_c, out_chan_d;
  logic [31:0] out_chan_e, out_chan_f, out_chan_g, out_chan_h;
  logic signed [47:0] out_energy;
  logic out_energy_invalid;
  logic cfg_we = 1'b0;
  logic [ScaleW-1:0] cfg_wdata = '0;

  scaler_word_t pending[$];
  frame_t frames_due[$];
  int mismatches = 0;
  int quiet = 0;
  bit timed_out = 1'b0;
  bit steady = 1'b0;

  // energy predictor state
  logic [ScaleW-1:0] scale_reg = '0;
  logic [SlotW-1:0] slot_at = '0;
  logic [WordCntW-1:0] words_seen = '0;
  logic [31:0] position = '0;
  logic [31:0] held [NumHold];

  scaler_frame_energy_decoder DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_count_word(in_count_word),
    .in_frame_start(in_frame_start),
    .in_encoder_start(in_encoder_start),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_chan_a(out_chan_a),
    .out_chan_b(out_chan_b),
    .out_chan_c(out_chan_c),
    .out_chan_d(out_chan_d),
    .out_chan_e(out_chan_e),
    .out_chan_f(out_chan_f),
    .out_chan_g(out_chan_g),
    .out_chan_h(out_chan_h),
    .out_energy(out_energy),
    .out_energy_invalid(out_energy_invalid),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] at_least_one(input logic [31:0] v);
    return (v == '0) ? 32'd1 : v;
  endfunction

  function automatic bit decode_word(input scaler_word_t w, output frame_t f);
    logic [31:0] mag;
    logic [63:0] quo;
    bit made;
    made = 1'b0;
    f = '0;
    if (w.start) begin
      slot_at = '0;
      words_seen = '0;
      position = w.enc;
    end
    if (words_seen < MaxWords) begin
      if (slot_at <= SlotChanD) begin
        held[slot_at] = at_least_one(w.data);
      end else if (slot_at == SlotSub) begin
        position = position - w.data;
      end else if (slot_at == SlotAdd) begin
        position = position + w.data;
      end else if (slot_at < SlotLast) begin
        held[slot_at - 2] = at_least_one(w.data);
      end else begin
        made = 1'b1;
        for (int k = 0; k < NumHold; k++) f.chan[k] = held[k];
        f.chan[NumChan-1] = at_least_one(w.data);
        if (position == '0) begin
          f.energy = '0;
          f.invalid = 1'b1;
        end else begin
          mag = position[31] ? -position : position;
          quo = {1'b0, scale_reg} / {32'd0, mag};
          if (!position[31]) begin
            f.energy = (quo > {1'b0, EnergyPosMaxQ}) ? EnergyPosMax : quo[EnergyW-1:0];
          end else begin
            f.energy = (quo > {1'b0, EnergyNegMaxQ}) ? EnergyNegMax : -quo[EnergyW-1:0];
          end
        end
      end
      slot_at = (slot_at == SlotLast) ? '0 : slot_at + 1'b1;
      words_seen = words_seen + 1'b1;
    end
    return made;
  endfunction

  function automatic void add_word(input logic [31:0] data, input bit start,
                                   input logic [31:0] enc);
    scaler_word_t w;
    w.data = data;
    w.start = start;
    w.enc = enc;
    pending.push_back(w);
  endfunction

  function automatic logic [31:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 15) return '1;
    if (r < 30) return $urandom_range(255);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_step();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 50) return $urandom_range(20);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_start();
    int r;
    r = $urandom_range(3);
    if (r == 0) return 32'($urandom_range(100)) - 32'd50;
    if (r == 1) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic void queue_waveform(input int len, input bit lead);
    logic [SlotW-1:0] slot;
    for (int i = 0; i < len; i++) begin
      slot = SlotW'(i % FrameSlots);
      add_word((slot == SlotSub || slot == SlotAdd) ? pick_step() : pick_count(),
               lead && i == 0, (lead && i == 0) ? pick_start() : $urandom);
    end
  endfunction

  function automatic void random_phase(input int words);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < words) begin
      r = $urandom_range(99);
      if (r < 80) begin
        len = FrameSlots * $urandom_range(1, 6);
        queue_waveform(len, 1'b1);
      end else if (r < 92) begin
        len = $urandom_range(1, 29);
        queue_waveform(len, 1'b1);
      end else begin
        len = $urandom_range(1, 5);
        queue_waveform(len, 1'b0);
      end
      sent += len;
    end
  endfunction

  task automatic drain();
    while (pending.size() != 0 || frames_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_scale(input logic [ScaleW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    scale_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void flag(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h actual %h", what, want, got);
  endfunction

  // input driver
  always @(posedge clk) begin : drive
    frame_t f;
    bit go;
    if (rst_n && in_push && !in_full) begin
      if (decode_word(pending[0], f)) frames_due.push_back(f);
      void'(pending.pop_front());
    end
    go = rst_n && pending.size() != 0 && (steady || $urandom_range(99) >= 20);
    in_push <= go;
    if (go) begin
      in_count_word <= pending[0].data;
      in_frame_start <= pending[0].start;
      in_encoder_start <= pending[0].enc;
    end
  end

  // result monitor
  always @(posedge clk) begin : watch
    frame_t got;
    frame_t want;
    if (rst_n && out_pop && out_empty === 1'b0) begin
      got.chan = {out_chan_h, out_chan_g, out_chan_f, out_chan_e,
                  out_chan_d, out_chan_c, out_chan_b, out_chan_a};
      got.energy = out_energy;
      got.invalid = out_energy_invalid;
      if (frames_due.size() == 0) begin
        flag("unexpected item, energy", '0, 64'(got.energy));
      end else begin
        want = frames_due.pop_front();
        for (int k = 0; k < NumChan; k++)
          if (got.chan[k] !== want.chan[k])
            flag($sformatf("chan %0d", k), 64'(want.chan[k]), 64'(got.chan[k]));
        if (got.energy !== want.energy)
          flag("energy", 64'(want.energy), 64'(got.energy));
        if (got.invalid !== want.invalid)
          flag("energy_invalid", 64'(want.invalid), 64'(got.invalid));
      end
    end
    out_pop <= steady || $urandom_range(99) >= 20;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin
    fork
      begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // no frame start after reset, position stays zero
        add_word('0, 1'b0, '1);
        add_word('1, 1'b0, '0);
        add_word(32'd1, 1'b0, '1);
        add_word(32'h8000_0000, 1'b0, '0);
        add_word('0, 1'b0, '1);
        add_word('0, 1'b0, '0);
        add_word('0, 1'b0, '1);
        add_word('1, 1'b0, '0);
        add_word(32'h5555_5555, 1'b0, '1);
        add_word('0, 1'b0, '0);
        drain();
        set_scale('1);
        // position one saturates high
        add_word(32'hAAAA_AAAA, 1'b1, 32'd1);
        for (int i = 1; i < FrameSlots; i++) add_word('0, 1'b0, $urandom);
        // position starts at the most positive value, then takes a random step and adds one
        add_word('1, 1'b1, 32'h7FFF_FFFF);
        for (int i = 1; i < FrameSlots; i++)
          add_word((SlotW'(i) == SlotAdd) ? 32'd1 : 32'($urandom), 1'b0, $urandom);
        drain();
        set_scale(ScaleW'({$urandom, $urandom}));
        random_phase(PhaseWords);
        drain();
        set_scale(ScaleW'({$urandom, $urandom} >> $urandom_range(40, 16)));
        random_phase(PhaseWords);
        drain();
        set_scale(ScaleW'(1));
        steady = 1'b1;
        random_phase(PhaseWords);
        drain();
        steady = 1'b0;
        set_scale('1);
        random_phase(PhaseWords);
        drain();
        set_scale('0);
        random_phase(PhaseWords / 2);
        drain();
        set_scale(ScaleW'({$urandom, $urandom} >> 20));
        random_phase(PhaseWords / 2);
        drain();
      end
      begin
        while (quiet < QuietLimit) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any
    if (!timed_out && mismatches == 0 && frames_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
